@@ rtl/rppe_pkg.sv @@
// Package: shared constants, types and helpers of the RGB pixel pulse encoder.
package rppe_pkg;

  localparam int ChanW     = 8;
  localparam int FrameBits = 3 * ChanW;
  localparam int CountW    = $clog2(FrameBits);
  localparam int TicksW    = 4;
  localparam int ProdW     = 2 * ChanW;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;

  localparam logic [TicksW-1:0] ONE_HIGH  = 4'd8;
  localparam logic [TicksW-1:0] ONE_LOW   = 4'd5;
  localparam logic [TicksW-1:0] ZERO_HIGH = 4'd4;
  localparam logic [TicksW-1:0] ZERO_LOW  = 4'd9;

  localparam logic [ChanW-1:0] BRIGHTNESS_RESET = 8'd20;
  localparam logic [ChanW-1:0] FLASH_RESET      = 8'd255;

  localparam logic [CountW-1:0] LAST_SYMBOL = CountW'(FrameBits - 1);

  typedef enum logic {
    REG_BRIGHTNESS = 1'b0,
    REG_FLASH      = 1'b1
  } reg_idx_t;

  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_FLASH = 1'b1
  } cmd_t;

  typedef logic [ProdW-1:0] prod_t;

  // exact floor(p / 255) for p up to 255*255
  function automatic logic [ChanW-1:0] div255(input prod_t p);
    logic [ProdW:0] t;
    t = {1'b0, p} + {9'd0, p[ProdW-1:ChanW]} + 17'd1;
    return t[ProdW-1:ChanW];
  endfunction

endpackage

@@ rtl/rgb_pixel_pulse_encoder_unit.sv @@
// Top level: RGB pixel pulse encoder, scale stage, byte stage, bit serializer, output register.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+----------------------------------------
//  s_ (in)   | s_tvalid / s_tready              | s_tdata {blue,green,red}, s_tuser cmd
//  m_ (out)  | m_tvalid / m_tready              | m_tdata {low_ticks,high_ticks}, m_tlast
//  apb       | psel, penable, pwrite, pready=1  | paddr, pwdata, prdata
//
// One item yields 24 symbols, one per cycle unless m_tready stalls; the serializer shift register
// sets the sustained item rate. An accepted item passes stages A, B, C and the output register.
// Synchronous reset empties every stage and loads brightness 20, flash level 255.
// A stall on m_tready freezes the output register and back-pressures each stage in turn.
module rgb_pixel_pulse_encoder_unit
  import rppe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic             s_tuser,   // cmd [0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // high_ticks [3:0], low_ticks [7:4]
  output logic             m_tlast,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [ChanW-1:0] brightness;
  logic [ChanW-1:0] flash_level;

  logic             a_valid;
  logic             a_cmd;
  prod_t            a_red;
  prod_t            a_green;
  prod_t            a_blue;

  logic                 b_valid;
  logic [FrameBits-1:0] b_frame;

  logic                 c_valid;
  logic [FrameBits-1:0] c_shift;
  logic [CountW-1:0]    c_count;

  logic out_load;
  logic c_emit;
  logic c_done;
  logic c_take;
  logic b_adv;
  logic a_adv;

  reg_idx_t wr_idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_idx = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness  <= BRIGHTNESS_RESET;
      flash_level <= FLASH_RESET;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_BRIGHTNESS: brightness  <= pwdata[ChanW-1:0];
        REG_FLASH:      flash_level <= pwdata[ChanW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_BRIGHTNESS: prdata = {{(DataW-ChanW){1'b0}}, brightness};
      REG_FLASH:      prdata = {{(DataW-ChanW){1'b0}}, flash_level};
      default:        prdata = '0;
    endcase
  end

  // stage flow control, back to front
  assign out_load = !m_tvalid || m_tready;
  assign c_emit   = c_valid && out_load;
  assign c_done   = c_emit && (c_count == LAST_SYMBOL);
  assign c_take   = b_valid && (!c_valid || c_done);
  assign b_adv    = !b_valid || c_take;
  assign a_adv    = !a_valid || b_adv;
  assign s_tready = a_adv;

  // stage A: scale products
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && s_tvalid) begin
      a_cmd   <= s_tuser;
      a_red   <= s_tdata[7:0]   * brightness;
      a_green <= s_tdata[15:8]  * brightness;
      a_blue  <= s_tdata[23:16] * brightness;
    end
  end

  // stage B: divide by full scale, select flash, order green, red, blue
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      if (cmd_t'(a_cmd) == CMD_FLASH) begin
        b_frame <= {flash_level, flash_level, flash_level};
      end else begin
        b_frame <= {div255(a_green), div255(a_red), div255(a_blue)};
      end
    end
  end

  // stage C: serializer, most significant bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      c_count <= '0;
    end else if (c_take) begin
      c_valid <= 1'b1;
      c_count <= '0;
    end else if (c_done) begin
      c_valid <= 1'b0;
      c_count <= '0;
    end else if (c_emit) begin
      c_count <= c_count + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (c_take) begin
      c_shift <= b_frame;
    end else if (c_emit) begin
      c_shift <= {c_shift[FrameBits-2:0], 1'b0};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_emit) begin
      m_tdata <= c_shift[FrameBits-1] ? {ONE_LOW, ONE_HIGH} : {ZERO_LOW, ZERO_HIGH};
      m_tlast <= (c_count == LAST_SYMBOL);
    end
  end

endmodule

@@ rtl/rppe_checker.sv @@
// Checker: port-level assertions of the RGB pixel pulse encoder, bound to the top level.
module rppe_checker
  import rppe_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [23:0]      s_tdata,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [7:0]       m_tdata,
  input logic             m_tlast,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [AddrW-1:0] paddr,
  input logic [DataW-1:0] pwdata,
  input logic [DataW-1:0] prdata,
  input logic             pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_symbol_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == {ONE_LOW, ONE_HIGH}) || (m_tdata == {ZERO_LOW, ZERO_HIGH}))
    else $error("symbol is neither a one nor a zero pulse");

  a_frame_gapless: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a symbol frame");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind rgb_pixel_pulse_encoder_unit rppe_checker u_rppe_checker (.*);

@@ dv/rgb_pixel_pulse_encoder_unit_tb.sv @@
// Testbench: random and directed colour items checked symbol by symbol against a local predictor.
module rgb_pixel_pulse_encoder_unit_tb
  import rppe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [TicksW-1:0] high_ticks;
    logic [TicksW-1:0] low_ticks;
    logic              last;
  } symbol_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic             s_tuser = 1'b0; // cmd [0]
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;        // high_ticks [3:0], low_ticks [7:4]
  logic             m_tlast;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  rgb_pixel_pulse_encoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  pixel_t     pending_pixels[$];
  symbol_t    expected_symbols[$];
  logic [7:0] brightness_cfg = BRIGHTNESS_RESET;
  logic [7:0] flash_cfg = FLASH_RESET;
  int         pixels_queued = 0;
  int         pixels_accepted = 0;
  int         mismatches = 0;
  int         idle_pct = 0;
  bit         calm = 1'b0;
  int         send_gap = 0;
  int         recv_stall = 0;

  function automatic logic [7:0] scale_channel(logic [7:0] c);
    return 8'((int'(c) * int'(brightness_cfg)) / 255);
  endfunction

  function automatic void predict_symbols(pixel_t p);
    logic [23:0] frame;
    symbol_t     s;
    if (p.cmd == CMD_FLASH) begin
      frame = {flash_cfg, flash_cfg, flash_cfg};
    end else begin
      frame = {scale_channel(p.green), scale_channel(p.red), scale_channel(p.blue)};
    end
    for (int k = 0; k < 24; k++) begin
      s.high_ticks = frame[23-k] ? ONE_HIGH : ZERO_HIGH;
      s.low_ticks  = frame[23-k] ? ONE_LOW : ZERO_LOW;
      s.last       = (k == 23);
      expected_symbols.push_back(s);
    end
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic void add_pixel(cmd_t c, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_t p;
    p.cmd   = c;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    pending_pixels.push_back(p);
    pixels_queued++;
  endfunction

  // sender: hold the item until accepted, idle in bursts between items
  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_symbols(pixel_t'({cmd_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
                                  s_tdata[23:16]}));
        pixels_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          if (!calm && $urandom_range(0, 99) < idle_pct) begin
            send_gap <= $urandom_range(0, 9);
            s_tvalid <= 1'b0;
          end else begin
            p = pending_pixels.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {p.blue, p.green, p.red};
            s_tuser  <= p.cmd;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall in bursts, compare each symbol with the oldest prediction
  always @(posedge clk) begin
    symbol_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_symbols.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected symbol: tdata=%h tlast=%b", m_tdata, m_tlast);
        end else begin
          want = expected_symbols.pop_front();
          if (m_tdata[3:0] !== want.high_ticks || m_tdata[7:4] !== want.low_ticks ||
              m_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("symbol mismatch: expected high=%0d low=%0d last=%b, got high=%0d low=%0d last=%b",
                       want.high_ticks, want.low_ticks, want.last,
                       m_tdata[3:0], m_tdata[7:4], m_tlast);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        m_tready   <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        recv_stall <= $urandom_range(0, 9);
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(int'(idx) * 4);
    pwdata  <= {24'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BRIGHTNESS)
      brightness_cfg = value;
    else
      flash_cfg = value;
  endtask

  task automatic drain();
    while (pixels_accepted != pixels_queued || expected_symbols.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(logic [7:0] bright, logic [7:0] flash, int count, int pct);
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_FLASH, flash);
    idle_pct = pct;
    add_pixel(CMD_SET, 8'd255, 8'd255, 8'd255);
    add_pixel(CMD_SET, 8'd0, 8'd0, 8'd0);
    add_pixel(CMD_FLASH, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    repeat (count)
      add_pixel($urandom_range(0, 3) == 0 ? CMD_FLASH : CMD_SET,
                pick_channel(), pick_channel(), pick_channel());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 30;
    add_pixel(CMD_SET, 8'd0, 8'd0, 8'd0);
    add_pixel(CMD_SET, 8'd255, 8'd255, 8'd255);
    add_pixel(CMD_SET, 8'd255, 8'd0, 8'd0);
    add_pixel(CMD_SET, 8'd0, 8'd255, 8'd0);
    add_pixel(CMD_SET, 8'd0, 8'd0, 8'd255);
    add_pixel(CMD_SET, 8'hAA, 8'h55, 8'hAA);
    add_pixel(CMD_SET, 8'h55, 8'hAA, 8'h55);
    add_pixel(CMD_SET, 8'd128, 8'd1, 8'd254);
    add_pixel(CMD_SET, 8'd13, 8'd51, 8'd204);
    add_pixel(CMD_SET, 8'd12, 8'd13, 8'd26);
    add_pixel(CMD_FLASH, 8'd0, 8'd0, 8'd0);
    add_pixel(CMD_FLASH, 8'd255, 8'd255, 8'd255);
    add_pixel(CMD_FLASH, 8'h5A, 8'hC3, 8'h3C);
    drain();

    run_phase(8'd255, 8'd0, 45, 0);
    run_phase(8'd0, 8'd255, 45, 40);
    run_phase(8'd1, 8'hAA, 45, 20);
    run_phase(8'd128, 8'h55, 45, 60);
    run_phase(8'($urandom()), 8'($urandom()), 45, 10);
    run_phase(8'd254, 8'd1, 45, 30);
    run_phase(8'($urandom()), 8'($urandom()), 45, 50);
    calm = 1'b1;
    run_phase(8'd255, 8'd255, 45, 0);

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("rgb_pixel_pulse_encoder_unit_tb: PASS");
    end else begin
      $display("rgb_pixel_pulse_encoder_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("rgb_pixel_pulse_encoder_unit_tb: FAIL");
    $finish;
  end

endmodule
